[src/ds_pkg.sv]
// Shared types and constants for the diamond-square height map generator.
package ds_pkg;

    // Sequencer phase: four corners, then alternating square and diamond passes.
    typedef enum logic [2:0] {
        PH_C0      = 3'd0,
        PH_C1      = 3'd1,
        PH_C2      = 3'd2,
        PH_C3      = 3'd3,
        PH_SQUARE  = 3'd4,
        PH_DIAMOND = 3'd5
    } phase_t;

    // Per-word control states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;

    // floor(t/3) == (t * DIV3_MUL) >> DIV3_SHIFT for every t below 2^19
    localparam logic signed [MUL_W-1:0] DIV3_MUL = 19'sd174763;
    localparam int DIV3_SHIFT = 19;

    localparam logic [15:0] ROUGH_RESET = 16'd32768;
    localparam logic [15:0] ROUGH_FLOOR = 16'd6554;   // 0.1 in Q0.16

endpackage

[src/ds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ds_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1089,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ds_mul.sv]
// Shared signed multiplier with a registered product.
module ds_mul import ds_pkg::*; (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

[src/diamond_square_heightmap.sv]
// Top level of the diamond-square height map generator.
//
// Every accepted random_sample word produces exactly one height point, in
// generation order: the four corners first, then for each level a square pass
// (cell centers from four corners) and a diamond pass (edge midpoints from the
// three or four neighbors inside the map). A corner is the sample itself; any
// other value is the rounded neighbor average plus round((2u-1)*roughness),
// clamped to [0, 65535]; roughness is latched from the roughness register at
// the first corner of a map and halves per level with a floor of 6554 (0.1).
// A corner word goes straight to the final step; any other word does four
// neighbor reads through the single read port of the height memory, an
// accumulate step and one pass through the shared multiplier for the divide by
// three. The final step writes the memory and loads the output register. The
// multiplier also forms the random offset while the reads run. in_ready is low
// while a word is being worked on; a finished point waits in the output
// register, and a new word is accepted while it waits. The height memory needs
// no clearing after reset, since a map only reads points it wrote earlier. The
// last flag marks the final point; the next word starts a fresh map. Roughness
// writes are taken at any time and act at the next map start.
module diamond_square_heightmap import ds_pkg::*; #(
    parameter int SIDE_LOG2 = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] random_sample,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pos_x,
    output logic [5:0]  pos_y,
    output logic [15:0] height,
    output logic        last,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] roughness
);

    localparam int E     = 1 << SIDE_LOG2;        // side minus one
    localparam int SIDE  = E + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int CW    = SIDE_LOG2 + 1;         // coordinate width
    localparam int AW    = $clog2(CELLS);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CW-1:0]     chunk_reg, chunk_next;
    logic [CW-1:0]     cur_x_reg, cur_x_next;
    logic [CW-1:0]     cur_y_reg, cur_y_next;
    logic [15:0]       cur_rough_reg, cur_rough_next;
    logic [15:0]       rough_reg;

    logic [1:0]        rd_idx_reg, rd_idx_next;
    logic              acc_en_reg, acc_en_next;
    logic [17:0]       sum_reg, sum_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [15:0]       u_reg;
    logic signed [17:0] off_reg;

    logic              out_valid_reg;
    logic [5:0]        pos_x_reg, pos_y_reg;
    logic [15:0]       height_reg;
    logic              last_reg;

    // ---------------------------------------------------------------
    // Datapath wires
    // ---------------------------------------------------------------
    logic [CW-1:0]     half;
    logic              is_corner;
    logic              in_fire, out_busy, step;

    logic [CW-1:0]     nb_x, nb_y;
    logic              nb_ok;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [15:0]       rd_data;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     mul_en;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;

    logic [CW-1:0]     pt_x, pt_y;
    logic [15:0]       avg, pt_val;
    logic signed [18:0] vsum;
    logic              pt_last;

    assign half      = chunk_reg >> 1;
    assign is_corner = (phase_reg != PH_SQUARE) && (phase_reg != PH_DIAMOND);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign step      = (state_reg == ST_FIN) && !out_busy;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Neighbor for the current read slot
    //   square:  (x,y) (x+c,y) (x,y+c) (x+c,y+c), all inside
    //   diamond: left, right, below, above at distance h, when inside
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [CW:0] xw, yw, cw, hw, ew;
        xw = {1'b0, cur_x_reg};
        yw = {1'b0, cur_y_reg};
        cw = {1'b0, chunk_reg};
        hw = {1'b0, half};
        ew = (CW+1)'(E);
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        nb_ok = 1'b1;
        if (phase_reg == PH_SQUARE)
        begin
            case (rd_idx_reg)
                2'd1:    nb_x = CW'(xw + cw);
                2'd2:    nb_y = CW'(yw + cw);
                2'd3:
                begin
                    nb_x = CW'(xw + cw);
                    nb_y = CW'(yw + cw);
                end
                default: ;
            endcase
        end
        else
        begin
            case (rd_idx_reg)
                2'd0:
                begin
                    nb_x  = CW'(xw - hw);
                    nb_ok = (xw >= hw);
                end
                2'd1:
                begin
                    nb_x  = CW'(xw + hw);
                    nb_ok = ((xw + hw) <= ew);
                end
                2'd2:
                begin
                    nb_y  = CW'(yw - hw);
                    nb_ok = (yw >= hw);
                end
                default:
                begin
                    nb_y  = CW'(yw + hw);
                    nb_ok = ((yw + hw) <= ew);
                end
            endcase
        end
    end

    // address = y*SIDE + x = (y << SIDE_LOG2) + y + x
    assign rd_addr = AW'({nb_y, {SIDE_LOG2{1'b0}}}) + AW'(nb_y) + AW'(nb_x);
    assign wr_addr = AW'({pt_y, {SIDE_LOG2{1'b0}}}) + AW'(pt_y) + AW'(pt_x);

    ds_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (wr_addr),
        .wr_data (pt_val),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Shared multiplier: random offset in the first read slot,
    // divide-by-three of the neighbor sum in ST_DIV.
    // ---------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            mul_a = $signed(MUL_W'({1'b0, sum_reg} + 19'd1));
            mul_b = DIV3_MUL;
        end
        else
        begin
            mul_a = $signed({2'b00, u_reg, 1'b0}) - $signed(MUL_W'(65536));
            mul_b = $signed({3'b000, cur_rough_reg});
        end
    end

    assign mul_en = ((state_reg == ST_READ) && (rd_idx_reg == 2'd0)) || (state_reg == ST_DIV);

    ds_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // round half up, then arithmetic shift by 16
    assign biased = prod + $signed(PROD_W'(32768));

    // ---------------------------------------------------------------
    // Point value and position
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [18:0] s1, s2;
        s1 = {1'b0, sum_reg} + 19'd1;
        s2 = {1'b0, sum_reg} + 19'd2;
        case (cnt_reg)
            3'd2:    avg = s1[16:1];
            3'd3:    avg = prod[DIV3_SHIFT+15:DIV3_SHIFT];
            3'd4:    avg = s2[17:2];
            default: avg = 16'd0;
        endcase
    end

    assign vsum = $signed({3'b000, avg}) + $signed({off_reg[17], off_reg});

    always_comb
    begin
        pt_x = cur_x_reg;
        pt_y = cur_y_reg;
        if (is_corner)
        begin
            pt_x   = (phase_reg == PH_C2 || phase_reg == PH_C3) ? CW'(E) : '0;
            pt_y   = (phase_reg == PH_C1 || phase_reg == PH_C3) ? CW'(E) : '0;
            pt_val = u_reg;
        end
        else
        begin
            if (phase_reg == PH_SQUARE)
            begin
                pt_x = cur_x_reg + half;
                pt_y = cur_y_reg + half;
            end
            if (vsum < 0)
                pt_val = 16'd0;
            else if (vsum > $signed(19'd65535))
                pt_val = 16'hFFFF;
            else
                pt_val = vsum[15:0];
        end
    end

    // ---------------------------------------------------------------
    // Map walk: phase, chunk, cursor and roughness advance per point
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [CW:0]  xc, yc, yh, ew;
        logic [15:0]  r_half;
        ew = (CW+1)'(E);
        xc = {1'b0, cur_x_reg} + {1'b0, chunk_reg};
        yc = {1'b0, cur_y_reg} + {1'b0, chunk_reg};
        yh = {1'b0, cur_y_reg} + {1'b0, half};
        r_half = cur_rough_reg >> 1;

        phase_next     = phase_reg;
        chunk_next     = chunk_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        cur_rough_next = cur_rough_reg;
        pt_last        = 1'b0;

        unique case (phase_reg)
            PH_SQUARE:
            begin
                cur_x_next = CW'(xc);
                if (xc >= ew)
                begin
                    cur_x_next = '0;
                    cur_y_next = CW'(yc);
                    if (yc >= ew)
                    begin
                        phase_next = PH_DIAMOND;
                        cur_y_next = '0;
                        cur_x_next = half;
                    end
                end
            end
            PH_DIAMOND:
            begin
                cur_x_next = CW'(xc);
                if (xc > ew)
                begin
                    cur_y_next = CW'(yh);
                    if (yh > ew)
                    begin
                        cur_rough_next = (r_half > ROUGH_FLOOR) ? r_half : ROUGH_FLOOR;
                        cur_x_next     = '0;
                        cur_y_next     = '0;
                        if (half > CW'(1))
                        begin
                            phase_next = PH_SQUARE;
                            chunk_next = half;
                        end
                        else
                        begin
                            pt_last    = 1'b1;
                            phase_next = PH_C0;
                            chunk_next = CW'(E);
                        end
                    end
                    else
                    begin
                        // chunk is a power of two: modulo is a mask
                        cur_x_next = CW'(yh + {1'b0, half}) & (chunk_reg - CW'(1));
                    end
                end
            end
            PH_C1:   phase_next = PH_C2;
            PH_C2:   phase_next = PH_C3;
            PH_C3:
            begin
                phase_next = PH_SQUARE;
                chunk_next = CW'(E);
                cur_x_next = '0;
                cur_y_next = '0;
            end
            default:
            begin
                // first corner, or a bad code: a new map starts here
                phase_next     = PH_C1;
                cur_rough_next = rough_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control FSM
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        acc_en_next = 1'b0;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        if (acc_en_reg)
        begin
            sum_next = sum_reg + {2'b00, rd_data};
            cnt_next = cnt_reg + 3'd1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                sum_next    = '0;
                cnt_next    = '0;
                rd_idx_next = '0;
                if (in_fire)
                begin
                    state_next = is_corner ? ST_FIN : ST_READ;
                end
            end
            ST_READ:
            begin
                acc_en_next = nb_ok;
                rd_idx_next = rd_idx_reg + 2'd1;
                if (rd_idx_reg == 2'd3)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_C0;
            chunk_reg     <= CW'(E);
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_rough_reg <= ROUGH_RESET;
            rough_reg     <= ROUGH_RESET;
            rd_idx_reg    <= '0;
            acc_en_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            acc_en_reg <= acc_en_next;
            cnt_reg    <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                rough_reg <= roughness;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                chunk_reg     <= chunk_next;
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                cur_rough_reg <= cur_rough_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (in_fire)
        begin
            u_reg <= random_sample;
        end
        if ((state_reg == ST_READ) && (rd_idx_reg == 2'd1))
        begin
            off_reg <= biased[33:16];
        end
        if (step)
        begin
            pos_x_reg  <= 6'(pt_x);
            pos_y_reg  <= 6'(pt_y);
            height_reg <= pt_val;
            last_reg   <= pt_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign height    = height_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    // a word in work holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while a word is in work");

    // a diamond point always has two to four neighbors inside the map
    a_diamond_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && (phase_reg == PH_DIAMOND) |->
            (cnt_reg == 3'd2) || (cnt_reg == 3'd3) || (cnt_reg == 3'd4))
        else $error("diamond neighbor count out of range");

    // the final point of a map is the top edge midpoint next to the far corner
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (pos_x == 6'(E - 1)) && (pos_y == 6'(E)))
        else $error("last flag on an unexpected point");
`endif

endmodule
